/* rtl/i2cm_pkg.sv */
// Shared types, constants and codes for the I2C register-transfer master.
`default_nettype none
package i2cm_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int Q_DEPTH    = 2;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DEV_NACK = 3'd1,
    ST_REG_NACK = 3'd2,
    ST_DAT_NACK = 3'd3,
    ST_REFUSED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_WBIT,
    PH_WACK,
    PH_RBIT,
    PH_RACK,
    PH_STOP
  } phase_t;

  typedef enum logic [2:0] {
    SG_DEVW,
    SG_REGHI,
    SG_REGLO,
    SG_DATA,
    SG_DEVR,
    SG_RDATA
  } stage_t;

  typedef struct packed {
    kind_t       kind;
    logic        sda_in;
    logic [6:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [1:0]  addr_bytes;
    logic        is_read;
    logic [7:0]  transfer_len;
    logic [7:0]  load_byte;
  } in_item_t;

endpackage
`default_nettype wire

/* rtl/i2cm_front.sv */
// Front end: unpack incoming items and hold them in a short queue.
`default_nettype none
module i2cm_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [i2cm_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]                   in_tuser,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output i2cm_pkg::in_item_t                q_item
);
  import i2cm_pkg::*;

  in_item_t    mem_r [Q_DEPTH];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  in_item_t    item;
  logic        push, pop;

  always_comb begin
    item.kind         = kind_t'(in_tuser);
    item.sda_in       = in_tdata[0];
    item.dev_addr     = in_tdata[7:1];
    item.reg_addr     = in_tdata[23:8];
    item.addr_bytes   = in_tdata[25:24];
    item.is_read      = in_tdata[26];
    item.transfer_len = in_tdata[34:27];
    item.load_byte    = in_tdata[42:35];
  end

  assign in_tready = (count_r != 2'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/i2cm_engine.sv */
// Back end: bus waveform sequencer, write buffer and result register.
`default_nettype none
module i2cm_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire i2cm_pkg::in_item_t            q_item,
  input  wire logic                          cfg_valid,
  input  wire logic [15:0]                   cfg_data,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);
  import i2cm_pkg::*;

  logic [7:0] buf_mem [BUF_DEPTH];

  logic [15:0]       half_r;
  phase_t            phase_r, phase_nxt;
  stage_t            stage_r, stage_nxt;
  logic [1:0]        seg_r, seg_nxt;
  logic              acked_r, acked_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        bidx_r, bidx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [6:0]        dev_r, dev_nxt;
  logic [15:0]       reg_r, reg_nxt;
  logic [1:0]        ab_r, ab_nxt;
  logic              rd_r, rd_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [1:0]        lines_r, lines_nxt;
  logic [7:0]        head_r, head_nxt;
  logic [7:0]        pref_r;

  logic              take, seg_end, refuse, wr_en, last;
  logic [16:0]       tick_inc;
  logic [15:0]       h;
  logic              go_wbyte, go_rbyte, go_start, go_stop;
  logic [7:0]        wbyte;
  logic [8:0]        bidx_inc;
  logic [BUF_AW-1:0] pref_addr;

  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic              out_last_r;
  logic [7:0]        o_data;
  logic              o_valid, o_done;
  status_t           o_status;
  logic [1:0]        o_lines;

  // Item moves from the queue whenever the result slot is free or draining.
  assign take     = q_valid && (!out_valid_r || out_tready);
  assign q_ready  = (!out_valid_r || out_tready);
  assign h        = (half_r == 16'd0) ? 16'd1 : half_r;
  assign tick_inc = {1'b0, tick_r} + 17'd1;
  assign bidx_inc = {1'b0, bidx_r} + 9'd1;
  assign last     = (bidx_inc == {1'b0, len_r});
  assign refuse   = (q_item.kind == KIND_START) &&
                    ((phase_r != PH_IDLE) || (q_item.addr_bytes == 2'd3) ||
                     (!q_item.is_read && ({1'b0, q_item.transfer_len} >
                                          9'(fill_r))));

  // Next state
  always_comb begin
    phase_nxt = phase_r;  stage_nxt = stage_r;  seg_nxt  = seg_r;
    acked_nxt = acked_r;  tick_nxt  = tick_r;   bit_nxt  = bit_r;
    shift_nxt = shift_r;  bidx_nxt  = bidx_r;   fill_nxt = fill_r;
    dev_nxt   = dev_r;    reg_nxt   = reg_r;    ab_nxt   = ab_r;
    rd_nxt    = rd_r;     len_nxt   = len_r;    lines_nxt = lines_r;
    head_nxt  = head_r;
    seg_end = 1'b0; wr_en = 1'b0;
    go_wbyte = 1'b0; go_rbyte = 1'b0; go_start = 1'b0; go_stop = 1'b0;
    wbyte = 8'd0;
    if (take) begin
      case (q_item.kind)
        KIND_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (tick_inc >= {1'b0, h}) begin
              tick_nxt = 16'd0;
              seg_end  = 1'b1;
            end else begin
              tick_nxt = tick_inc[15:0];
            end
          end
        end
        KIND_LOAD: begin
          if (phase_r == PH_IDLE && fill_r < FILL_W'(BUF_DEPTH)) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + FILL_W'(1);
            if (fill_r == '0) begin
              head_nxt = q_item.load_byte;
            end
          end
        end
        KIND_START: begin
          if (!refuse) begin
            dev_nxt  = q_item.dev_addr;
            reg_nxt  = q_item.reg_addr;
            ab_nxt   = q_item.addr_bytes;
            rd_nxt   = q_item.is_read;
            len_nxt  = q_item.transfer_len;
            if (!q_item.is_read) begin
              fill_nxt = '0;
            end
            bidx_nxt  = 8'd0;
            tick_nxt  = 16'd0;
            stage_nxt = (q_item.is_read && q_item.addr_bytes == 2'd0) ? SG_DEVR : SG_DEVW;
            go_start  = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (seg_end) begin
      case (phase_r)
        PH_START: begin
          if (seg_r == 2'd0) begin
            seg_nxt = 2'd1; lines_nxt = 2'b10;
          end else if (seg_r == 2'd1) begin
            seg_nxt = 2'd2; lines_nxt = 2'b00;
          end else begin
            go_wbyte = 1'b1;
            wbyte    = {dev_r, (stage_r == SG_DEVR)};
          end
        end
        PH_WBIT: begin
          if (seg_r == 2'd0) begin
            seg_nxt = 2'd1; lines_nxt = {1'b1, shift_r[7]};
          end else if (bit_r == 3'd7) begin
            phase_nxt = PH_WACK; seg_nxt = 2'd0; lines_nxt = 2'b01;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            shift_nxt = {shift_r[6:0], 1'b0};
            seg_nxt   = 2'd0;
            lines_nxt = {1'b0, shift_r[6]};
          end
        end
        PH_WACK: begin
          if (seg_r == 2'd0) begin
            seg_nxt = 2'd1; lines_nxt = 2'b11;
          end else if (seg_r == 2'd1) begin
            acked_nxt = !q_item.sda_in;
            seg_nxt = 2'd2; lines_nxt = 2'b01;
          end else if (!acked_r) begin
            phase_nxt = PH_IDLE;
          end else begin
            case (stage_r)
              SG_DEVW, SG_REGHI, SG_REGLO: begin
                if (stage_r == SG_DEVW && ab_r == 2'd2) begin
                  stage_nxt = SG_REGHI; go_wbyte = 1'b1; wbyte = reg_r[15:8];
                end else if ((stage_r == SG_DEVW && ab_r == 2'd1) ||
                             stage_r == SG_REGHI) begin
                  stage_nxt = SG_REGLO; go_wbyte = 1'b1; wbyte = reg_r[7:0];
                end else if (rd_r) begin
                  stage_nxt = SG_DEVR; go_start = 1'b1;
                end else if (len_r != 8'd0) begin
                  stage_nxt = SG_DATA; bidx_nxt = 8'd0;
                  go_wbyte = 1'b1; wbyte = head_r;
                end else begin
                  go_stop = 1'b1;
                end
              end
              SG_DATA: begin
                bidx_nxt = bidx_inc[7:0];
                if (bidx_inc < {1'b0, len_r}) begin
                  go_wbyte = 1'b1; wbyte = pref_r;
                end else begin
                  go_stop = 1'b1;
                end
              end
              default: begin
                if (len_r == 8'd0) begin
                  go_stop = 1'b1;
                end else begin
                  stage_nxt = SG_RDATA; bidx_nxt = 8'd0; go_rbyte = 1'b1;
                end
              end
            endcase
          end
        end
        PH_RBIT: begin
          if (seg_r == 2'd0) begin
            shift_nxt = {shift_r[6:0], q_item.sda_in};
            seg_nxt = 2'd1; lines_nxt = 2'b01;
          end else if (bit_r == 3'd7) begin
            phase_nxt = PH_RACK; seg_nxt = 2'd0; lines_nxt = {1'b1, last};
          end else begin
            bit_nxt = bit_r + 3'd1; seg_nxt = 2'd0; lines_nxt = 2'b11;
          end
        end
        PH_RACK: begin
          if (seg_r == 2'd0) begin
            seg_nxt = 2'd1; lines_nxt = {1'b0, last};
          end else begin
            bidx_nxt = bidx_inc[7:0];
            if (bidx_inc < {1'b0, len_r}) begin
              go_rbyte = 1'b1;
            end else begin
              go_stop = 1'b1;
            end
          end
        end
        PH_STOP: begin
          lines_nxt = 2'b11;
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (go_start) begin
      phase_nxt = PH_START; seg_nxt = 2'd0; lines_nxt = 2'b11;
    end
    if (go_wbyte) begin
      phase_nxt = PH_WBIT; shift_nxt = wbyte; bit_nxt = 3'd0;
      seg_nxt = 2'd0; lines_nxt = {1'b0, wbyte[7]};
    end
    if (go_rbyte) begin
      phase_nxt = PH_RBIT; shift_nxt = 8'd0; bit_nxt = 3'd0;
      seg_nxt = 2'd0; lines_nxt = 2'b11;
    end
    if (go_stop) begin
      phase_nxt = PH_STOP; lines_nxt = 2'b10;
    end
  end

  // Result fields
  always_comb begin
    o_valid  = seg_end && (phase_r == PH_RBIT) && (seg_r == 2'd0) && (bit_r == 3'd7);
    o_data   = o_valid ? {shift_r[6:0], q_item.sda_in} : 8'd0;
    o_done   = 1'b0;
    o_status = ST_OK;
    if (take && q_item.kind == KIND_START && refuse) begin
      o_done = 1'b1; o_status = ST_REFUSED;
    end else if (seg_end && phase_r == PH_STOP) begin
      o_done = 1'b1;
    end else if (seg_end && phase_r == PH_WACK && seg_r == 2'd2 && !acked_r) begin
      o_done = 1'b1;
      case (stage_r)
        SG_DEVW, SG_DEVR: o_status = ST_DEV_NACK;
        SG_DATA:          o_status = ST_DAT_NACK;
        default:          o_status = ST_REG_NACK;
      endcase
    end
    o_lines = (q_item.kind == KIND_START) ? lines_nxt : lines_r;
  end

  // Keep the next data byte staged one entry ahead of byte index.
  assign pref_addr = bidx_nxt[BUF_AW-1:0] + BUF_AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[fill_r[BUF_AW-1:0]] <= q_item.load_byte;
    end
    pref_r <= buf_mem[pref_addr];
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    dev_r   <= dev_nxt;
    reg_r   <= reg_nxt;
    head_r  <= head_nxt;
    if (take) begin
      out_data_r <= {(phase_nxt != PH_IDLE), o_status, o_done, o_valid, o_data,
                     o_lines[0], o_lines[1]};
      out_last_r <= o_valid && last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= 16'd5;
      phase_r     <= PH_IDLE;
      stage_r     <= SG_DEVW;
      seg_r       <= 2'd0;
      acked_r     <= 1'b0;
      tick_r      <= 16'd0;
      bit_r       <= 3'd0;
      bidx_r      <= 8'd0;
      fill_r      <= '0;
      ab_r        <= 2'd0;
      rd_r        <= 1'b0;
      len_r       <= 8'd0;
      lines_r     <= 2'b11;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        half_r <= cfg_data;
      end
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      seg_r   <= seg_nxt;
      acked_r <= acked_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      bidx_r  <= bidx_nxt;
      fill_r  <= fill_nxt;
      ab_r    <= ab_nxt;
      rd_r    <= rd_nxt;
      len_r   <= len_nxt;
      lines_r <= lines_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
endmodule
`default_nettype wire

/* rtl/i2c_master_register_transfer.sv */
// Top level of the tick-paced I2C master for register transfers.
`default_nettype none
// Usage: every input item produces exactly one result item, in order. The
// block takes one item per clock when the result side keeps up; a two-item
// queue sits in front of the sequencer and a result register behind it, so
// either side may stall on its own. Tick items (tuser 0) advance the SCL/SDA
// waveform; each waveform segment lasts half_period_ticks ticks (0 acts as
// 1). Load items (tuser 1) append a byte to the 32-byte write buffer while
// idle; start items (tuser 2) launch a transfer or are refused with status 4.
// Write half_period_ticks through the cfg port only while the block is idle;
// the new value applies at once. The buffer is a memory with a registered
// read port that keeps the next data byte staged; its contents are not
// cleared at reset. A NACK from the target aborts without a STOP condition.
module i2c_master_register_transfer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // sda_in[0], dev_addr[7:1], reg_addr[23:8], addr_bytes[25:24],
  // is_read[26], transfer_len[34:27], load_byte[42:35], zeros above
  input  wire logic [47:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // scl_out[0], sda_out[1], read_data[9:2], read_valid[10], done_res[11],
  // status[14:12], busy_res[15]
  output logic [15:0]      out_tdata,
  // read_last
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  logic     q_valid, q_ready;
  in_item_t q_item;

  // Config writes are always taken.
  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  i2cm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule
`default_nettype wire

/* sim/i2c_master_register_transfer_checker.sv */
// Bus checker for the I2C register-transfer master: predicts and compares every result item.
`timescale 1ns / 100ps
module i2c_master_register_transfer_checker
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending_count,
  output logic             xfer_busy
);

  typedef struct {
    logic       scl;
    logic       sda;
    logic [7:0] data;
    logic       vld;
    logic       last;
    logic       done;
    logic [2:0] st;
    logic       busy;
  } bus_result_t;

  bus_result_t bus_results_q[$];
  int          n_fail;

  // predicted block state
  logic [15:0] half_ticks;
  phase_t      ph;
  stage_t      stg;
  logic [1:0]  seg;
  logic [15:0] tick_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  shreg;
  logic [7:0]  byte_idx;
  logic [7:0]  wbuf [BUF_DEPTH];
  logic [5:0]  fill;
  logic [6:0]  c_dev;
  logic [15:0] c_reg;
  logic [1:0]  c_abytes;
  logic        c_rd;
  logic [7:0]  c_len;
  logic        scl_lv, sda_lv, acked;
  bus_result_t r;

  task automatic lines(input logic scl, input logic sda);
    scl_lv = scl;
    sda_lv = sda;
  endtask

  task automatic begin_start();
    ph = PH_START;
    seg = 0;
    lines(1, 1);
  endtask

  task automatic begin_wbyte(input logic [7:0] b);
    ph = PH_WBIT;
    shreg = b;
    bit_idx = 0;
    seg = 0;
    lines(0, b[7]);
  endtask

  task automatic begin_rbyte();
    ph = PH_RBIT;
    shreg = 0;
    bit_idx = 0;
    seg = 0;
    lines(1, 1);
  endtask

  task automatic begin_stop();
    ph = PH_STOP;
    lines(1, 0);
  endtask

  task automatic finish_xfer(input status_t s);
    ph = PH_IDLE;
    r.done = 1;
    r.st = s;
  endtask

  task automatic after_reg();
    if (c_rd) begin
      stg = SG_DEVR;
      begin_start();
    end else if (c_len > 0) begin
      stg = SG_DATA;
      byte_idx = 0;
      begin_wbyte(wbuf[0]);
    end else begin
      begin_stop();
    end
  endtask

  task automatic after_ack();
    case (stg)
      SG_DEVW: begin
        if (c_abytes == 2) begin
          stg = SG_REGHI;
          begin_wbyte(c_reg[15:8]);
        end else if (c_abytes == 1) begin
          stg = SG_REGLO;
          begin_wbyte(c_reg[7:0]);
        end else begin
          after_reg();
        end
      end
      SG_REGHI: begin
        stg = SG_REGLO;
        begin_wbyte(c_reg[7:0]);
      end
      SG_REGLO: after_reg();
      SG_DATA: begin
        byte_idx = byte_idx + 1;
        if (byte_idx < c_len) begin_wbyte(wbuf[byte_idx[4:0]]);
        else begin_stop();
      end
      default: begin
        if (c_len == 0) begin
          begin_stop();
        end else begin
          stg = SG_RDATA;
          byte_idx = 0;
          begin_rbyte();
        end
      end
    endcase
  endtask

  task automatic segment_end(input logic s);
    logic fin;
    fin = ({1'b0, byte_idx} + 9'd1 == {1'b0, c_len});
    case (ph)
      PH_START: begin
        if (seg == 0) begin
          seg = 1;
          lines(1, 0);
        end else if (seg == 1) begin
          seg = 2;
          lines(0, 0);
        end else begin
          begin_wbyte({c_dev, stg == SG_DEVR});
        end
      end
      PH_WBIT: begin
        if (seg == 0) begin
          seg = 1;
          lines(1, shreg[7]);
        end else if (bit_idx == 7) begin
          ph = PH_WACK;
          seg = 0;
          lines(0, 1);
        end else begin
          bit_idx = bit_idx + 1;
          shreg = shreg << 1;
          seg = 0;
          lines(0, shreg[7]);
        end
      end
      PH_WACK: begin
        if (seg == 0) begin
          seg = 1;
          lines(1, 1);
        end else if (seg == 1) begin
          acked = (s == 0);
          seg = 2;
          lines(0, 1);
        end else if (!acked) begin
          if (stg == SG_DEVW || stg == SG_DEVR) finish_xfer(ST_DEV_NACK);
          else if (stg == SG_DATA) finish_xfer(ST_DAT_NACK);
          else finish_xfer(ST_REG_NACK);
        end else begin
          after_ack();
        end
      end
      PH_RBIT: begin
        if (seg == 0) begin
          shreg = {shreg[6:0], s};
          if (bit_idx == 7) begin
            r.vld = 1;
            r.data = shreg;
            r.last = fin;
          end
          seg = 1;
          lines(0, 1);
        end else if (bit_idx == 7) begin
          ph = PH_RACK;
          seg = 0;
          lines(1, fin);
        end else begin
          bit_idx = bit_idx + 1;
          seg = 0;
          lines(1, 1);
        end
      end
      PH_RACK: begin
        if (seg == 0) begin
          seg = 1;
          lines(0, fin);
        end else begin
          byte_idx = byte_idx + 1;
          if (byte_idx < c_len) begin_rbyte();
          else begin_stop();
        end
      end
      PH_STOP: begin
        lines(1, 1);
        finish_xfer(ST_OK);
      end
      default: ph = PH_IDLE;
    endcase
  endtask

  // Work out the result of one accepted input item and advance the state.
  task automatic predict_item(input logic [1:0] k, input logic [47:0] d);
    logic [15:0] h;
    logic        l_scl, l_sda;
    r = '{default: '0};
    l_scl = scl_lv;
    l_sda = sda_lv;
    case (kind_t'(k))
      KIND_TICK: begin
        if (ph != PH_IDLE) begin
          h = (half_ticks == 0) ? 16'd1 : half_ticks;
          tick_cnt = tick_cnt + 1;
          if (tick_cnt >= h) begin
            tick_cnt = 0;
            segment_end(d[0]);
          end
        end
      end
      KIND_LOAD: begin
        if (ph == PH_IDLE && fill < BUF_DEPTH) begin
          wbuf[fill[4:0]] = d[42:35];
          fill = fill + 1;
        end
      end
      KIND_START: begin
        if (ph != PH_IDLE || d[25:24] == 2'd3 || (!d[26] && d[34:27] > fill)) begin
          r.done = 1;
          r.st = ST_REFUSED;
        end else begin
          c_dev = d[7:1];
          c_reg = d[23:8];
          c_abytes = d[25:24];
          c_rd = d[26];
          c_len = d[34:27];
          if (!c_rd) fill = 0;
          byte_idx = 0;
          tick_cnt = 0;
          stg = (c_rd && c_abytes == 0) ? SG_DEVR : SG_DEVW;
          begin_start();
        end
        l_scl = scl_lv;
        l_sda = sda_lv;
      end
      default: ;
    endcase
    r.scl = l_scl;
    r.sda = l_sda;
    r.busy = (ph != PH_IDLE);
    bus_results_q.push_back(r);
  endtask

  task automatic check_result();
    bus_result_t e;
    if (bus_results_q.size() == 0) begin
      n_fail++;
      if (n_fail <= 10) $display("%0t: result item with nothing expected: %h", $time, out_tdata);
      return;
    end
    e = bus_results_q.pop_front();
    if (out_tdata[0] !== e.scl || out_tdata[1] !== e.sda || out_tdata[9:2] !== e.data ||
        out_tdata[10] !== e.vld || out_tlast !== e.last || out_tdata[11] !== e.done ||
        out_tdata[14:12] !== e.st || out_tdata[15] !== e.busy) begin
      n_fail++;
      if (n_fail <= 10)
        $display("%0t: mismatch exp scl %b sda %b data %h vld %b last %b done %b st %0d busy %b",
                 $time, e.scl, e.sda, e.data, e.vld, e.last, e.done, e.st, e.busy,
                 " / got scl %b sda %b data %h vld %b last %b done %b st %0d busy %b",
                 out_tdata[0], out_tdata[1], out_tdata[9:2], out_tdata[10], out_tlast,
                 out_tdata[11], out_tdata[14:12], out_tdata[15]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      half_ticks = 16'd5;
      ph = PH_IDLE;
      stg = SG_DEVW;
      seg = 0;
      tick_cnt = 0;
      bit_idx = 0;
      shreg = 0;
      byte_idx = 0;
      fill = 0;
      {c_dev, c_reg, c_abytes, c_rd, c_len} = '0;
      scl_lv = 1;
      sda_lv = 1;
      acked = 0;
      for (int i = 0; i < BUF_DEPTH; i++) wbuf[i] = 8'h00;
      bus_results_q.delete();
      n_fail = 0;
    end else begin
      // retire first: a result can never belong to the item accepted at this edge
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) half_ticks = cfg_data;
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
    fail_count <= n_fail;
    pending_count <= bus_results_q.size();
    xfer_busy <= (ph != PH_IDLE);
  end

endmodule

/* sim/i2c_master_register_transfer_tb.sv */
// Testbench top for the I2C register-transfer master: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module i2c_master_register_transfer_tb;
  import i2cm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending_count;
  logic        xfer_busy;

  int n_sent;       // input items accepted so far
  int tb_fill;      // rough view of the write buffer fill
  bit no_gaps;      // burst mode: hold in_tvalid high back to back

  i2c_master_register_transfer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  i2c_master_register_transfer_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count), .xfer_busy(xfer_busy)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [47:0] pack_item(logic sda, logic [6:0] dev, logic [15:0] rg,
                                            logic [1:0] ab, logic rd, logic [7:0] len,
                                            logic [7:0] lb);
    return {5'b0, lb, len, rd, ab, rg, dev, sda};
  endfunction

  function automatic logic [47:0] noise_fields();
    return {5'b0, 43'($urandom()) ^ (43'($urandom()) << 32)};
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input kind_t k, input logic [47:0] d);
    int g;
    g = no_gaps ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic load_bytes(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(KIND_LOAD, {5'b0, 8'($urandom()), 35'($urandom())});
      if (tb_fill < BUF_DEPTH) tb_fill++;
    end
  endtask

  // SDA seen on one tick: mode 0 mostly ACKs, mode 1 coin flips, mode 2 line held high.
  function automatic logic sda_sample(int mode);
    if (mode == 2) return 1'b1;
    if (mode == 1) return 1'($urandom());
    return ($urandom_range(0, 99) < 2);
  endfunction

  // Issue a start, then tick until the transaction is over.
  task automatic run_xfer(input logic [6:0] dev, input logic [15:0] rg, input logic [1:0] ab,
                          input logic rd, input logic [7:0] len, input int mode,
                          input bit noise);
    int n_ticks;
    logic [47:0] d;
    d = pack_item(1'($urandom()), dev, rg, ab, rd, len, 8'($urandom()));
    send_item(KIND_START, d);
    if (!rd && ab != 2'd3 && len <= tb_fill) tb_fill = 0;
    n_ticks = 0;
    do begin
      if (noise && $urandom_range(0, 29) == 0) begin
        // junk while busy: unused kind, ignored load, refused start
        case ($urandom_range(0, 2))
          0: send_item(KIND_NONE, noise_fields());
          1: send_item(KIND_LOAD, noise_fields());
          default: send_item(KIND_START, noise_fields());
        endcase
      end else begin
        d = noise_fields();
        d[0] = sda_sample(mode);
        send_item(KIND_TICK, d);
      end
      n_ticks++;
    end while (xfer_busy && n_ticks < 20000);
  endtask

  task automatic random_xfer();
    logic       rd;
    logic [1:0] ab;
    logic [7:0] len;
    int p, mode;
    no_gaps = ($urandom_range(0, 9) < 3);
    load_bytes(($urandom_range(0, 19) == 0) ? 33 : $urandom_range(0, 5));
    rd = 1'($urandom());
    p = $urandom_range(0, 99);
    ab = (p < 5) ? 2'd3 : 2'($urandom_range(0, 2));
    if (rd) len = 8'($urandom_range(0, 4));
    else if ($urandom_range(0, 19) == 0) len = 8'(tb_fill + 1);
    else len = 8'($urandom_range(0, (tb_fill > 6) ? 6 : tb_fill));
    p = $urandom_range(0, 99);
    mode = (p < 70) ? 0 : (p < 95) ? 1 : 2;
    run_xfer(7'($urandom()), 16'($urandom()), ab, rd, len, mode, 1'b1);
  endtask

  // Wait for a quiet block, then write the half period.
  task automatic set_half_period(input logic [15:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || xfer_busy) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: ready for a stretch, then stalled for a gap.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 8))
        @(posedge clk);
      if (gap_len() > 0) begin
        out_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int target;
    logic [15:0] halves [5];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_TICK;
    cfg_valid = 1'b0;
    cfg_data = '0;
    n_sent = 0;
    tb_fill = 0;
    no_gaps = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset half period
    send_item(KIND_NONE, {5'b0, {43{1'b1}}});
    send_item(KIND_TICK, {5'b0, {43{1'b1}}});                    // idle tick
    send_item(KIND_START, pack_item(0, 0, 0, 2'd3, 1, 0, 0));    // bad address count
    send_item(KIND_START, pack_item(1, 7'h7f, 16'hffff, 2'd0, 0, 8'hff, 8'hff)); // len > fill
    send_item(KIND_LOAD, pack_item(0, 0, 0, 0, 0, 0, 8'h00));
    send_item(KIND_LOAD, pack_item(0, 0, 0, 0, 0, 0, 8'hff));
    tb_fill = 2;
    run_xfer(7'h7f, 16'hffff, 2'd2, 0, 8'd2, 0, 0);   // full write, mode 0 mostly ACKs
    run_xfer(7'h00, 16'h0000, 2'd0, 0, 8'd0, 0, 0);   // probe
    run_xfer(7'h2a, 16'h00a5, 2'd1, 1, 8'd3, 1, 0);   // read with register byte
    run_xfer(7'h55, 16'h1234, 2'd0, 1, 8'd0, 0, 1);   // read, nothing to receive
    run_xfer(7'h13, 16'h8001, 2'd2, 1, 8'hff, 2, 0);  // device never answers
    load_bytes(33);                                    // last load hits a full buffer
    run_xfer(7'h40, 16'h00ff, 2'd1, 0, 8'd1, 2, 0);   // device address NACKed, SDA held high
    load_bytes(2);
    run_xfer(7'h41, 16'h0000, 2'd0, 0, 8'd2, 1, 1);

    // walk through settings, zero among them; the top value follows
    halves = '{16'd1, 16'd0, 16'd3, 16'd2, 16'd1};
    target = n_sent;
    foreach (halves[i]) begin
      set_half_period(halves[i]);
      target += 280;
      while (n_sent < target) random_xfer();
    end
    set_half_period(16'hffff);
    load_bytes(3);
    run_xfer(7'h11, 16'h0000, 2'd3, 0, 8'd0, 0, 0);   // refused, stays idle
    send_item(KIND_NONE, noise_fields());

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
